### rtl/epd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg
// shared constants, codes and types of the pairwise distance core
// ----------------------------------------------------------------------------
package epd_pkg;

   // default sizing
   localparam int DEF_MAX_VECTORS    = 64;
   localparam int DEF_MAX_DIMENSIONS = 64;
   localparam int DEF_FEATURE_BITS   = 16;

   // fixed port widths
   localparam int OP_W      = 1;
   localparam int IDX_W     = 6;
   localparam int FEAT_IN_W = 16;
   localparam int DIST_W    = 19;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_EMIT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION_COUNT = 1'b1;

   // register reset values
   localparam logic [CFG_W-1:0] VECTOR_COUNT_RST    = 7'd64;
   localparam logic [CFG_W-1:0] DIMENSION_COUNT_RST = 7'd64;

   // square root unit status
   typedef struct packed {
      logic busy;
      logic done;
   } epd_sqrt_stat_type;

endpackage

### rtl/euclidean_pairwise_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_pairwise_distance_core
// rows of the strictly lower triangular euclidean distance matrix
// ----------------------------------------------------------------------------
// A load transfer writes one feature. An emit transfer for row i streams i
// results, columns 0 to i-1 in order, each the floor of the square root of
// the exact squared distance; rsp_last marks column i-1 and row 0 or a row
// outside vector_count gives nothing. Results are strobed on rsp_valid for
// one cycle and cannot be held off, so the receiver must take every one.
// busy is high from the accepted emit until the last root is done, and the
// last result is strobed once busy is low. For each column, one feature of
// row i and one of row j are read per cycle from the two read ports of the
// feature ram, followed by a three-stage difference/square/accumulate pipe
// and a handoff. The square root is a one-bit-per-cycle unit (20 steps at
// the default sizing) that runs while the next column accumulates, so it
// only adds to the emit time when dimension_count is below 16, and once
// at the end of the row. There is no clearing pass: the feature ram must be
// loaded before it is used.
// ----------------------------------------------------------------------------
module euclidean_pairwise_distance_core
   import epd_pkg::*;
#(
   parameter int MAX_VECTORS    = DEF_MAX_VECTORS,
   parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
   parameter int FEATURE_BITS   = DEF_FEATURE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,

   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [OP_W-1:0]             req_operation,
   input  logic [IDX_W-1:0]            req_row,
   input  logic [IDX_W-1:0]            req_dimension,
   input  logic signed [FEAT_IN_W-1:0] req_feature,

   // result channel
   output logic                        rsp_valid,
   output logic [IDX_W-1:0]            rsp_row_index,
   output logic [IDX_W-1:0]            rsp_column_index,
   output logic [DIST_W-1:0]           rsp_distance,
   output logic                        rsp_last,

   // register write port
   input  logic                        csr_write_enable,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_write_data
);

   // sizing
   localparam int RW       = $clog2(MAX_VECTORS);
   localparam int DW       = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
   localparam int AW       = RW + DW;
   localparam int VC_W     = ($clog2(MAX_VECTORS + 1) > CFG_W) ?
                             $clog2(MAX_VECTORS + 1) : CFG_W;
   localparam int DC_W     = ($clog2(MAX_DIMENSIONS + 1) > CFG_W) ?
                             $clog2(MAX_DIMENSIONS + 1) : CFG_W;
   localparam int DIFF_W   = FEATURE_BITS + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int SQ_FULL  = 2 * FEATURE_BITS + 1;
   localparam int SQ_W     = (SQ_FULL > 64) ? 64 : SQ_FULL;
   localparam int SUM_FULL = SQ_FULL + $clog2(MAX_DIMENSIONS);
   localparam int SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
   localparam int RT_W     = (SUM_W + 1) / 2;

   localparam logic [VC_W-1:0] MAX_ROWS = VC_W'(MAX_VECTORS);
   localparam logic [DC_W-1:0] MAX_COLS = DC_W'(MAX_DIMENSIONS);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_HAND  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   // configuration
   logic [CFG_W-1:0]  vector_count_ff,    vector_count_in;
   logic [CFG_W-1:0]  dimension_count_ff, dimension_count_in;
   logic [VC_W-1:0]   vc_ext;
   logic [DC_W-1:0]   dc_ext;
   logic [VC_W-1:0]   nrows;
   logic [DC_W-1:0]   ndims;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic [RW-1:0]     row_ff,   row_in;
   logic [RW-1:0]     j_ff,     j_in;
   logic [DW-1:0]     t_ff,     t_in;
   logic              issue;
   logic              t_last;
   logic              pair_last;

   // datapath pipe
   logic              rd_v_ff, rd_v_in;
   logic              df_v_ff, df_v_in;
   logic              sq_v_ff, sq_v_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [SQ_W-1:0]   sq_ff,   sq_in;
   logic [SUM_W-1:0]  sum_ff,  sum_in;
   logic signed [PROD_W-1:0] prod;

   // tags of the column in the square root unit
   logic [RW-1:0]     tag_col_ff,  tag_col_in;
   logic              tag_last_ff, tag_last_in;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_ff,   rsp_row_in;
   logic [IDX_W-1:0]  rsp_col_ff,   rsp_col_in;
   logic [DIST_W-1:0] rsp_dist_ff,  rsp_dist_in;
   logic              rsp_last_ff,  rsp_last_in;

   // command decode
   logic              accept;
   logic              load_ok;
   logic              emit_ok;

   // feature ram
   logic                    ram_we;
   logic [AW-1:0]           ram_wr_addr;
   logic [FEATURE_BITS-1:0] ram_wr_data;
   logic [AW-1:0]           ram_rd_addr_a;
   logic [AW-1:0]           ram_rd_addr_b;
   logic [FEATURE_BITS-1:0] ram_rd_data_a;
   logic [FEATURE_BITS-1:0] ram_rd_data_b;

   // square root unit
   logic                    sq_start;
   logic [RT_W-1:0]         sq_root;
   epd_sqrt_stat_type       sq_stat;

   // ---------------------------------------------------------------------
   // configuration registers, counts above the sizing act as the maximum
   // ---------------------------------------------------------------------
   always_comb begin
      vector_count_in    = vector_count_ff;
      dimension_count_in = dimension_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_VECTOR_COUNT:    vector_count_in    = csr_write_data;
            CSR_DIMENSION_COUNT: dimension_count_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign vc_ext = VC_W'(vector_count_ff);
   assign dc_ext = DC_W'(dimension_count_ff);
   assign nrows  = (vc_ext > MAX_ROWS) ? MAX_ROWS : vc_ext;
   assign ndims  = (dc_ext > MAX_COLS) ? MAX_COLS : dc_ext;

   // ---------------------------------------------------------------------
   // command decode
   // ---------------------------------------------------------------------
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign load_ok = (req_operation == OP_LOAD) && (VC_W'(req_row) < nrows) &&
                    (DC_W'(req_dimension) < ndims);
   assign emit_ok = (req_operation == OP_EMIT) && (req_row != '0) &&
                    (VC_W'(req_row) < nrows);

   // load transfer writes straight into the ram, the input is sign extended
   // or wrapped to the stored feature width
   assign ram_we        = accept && load_ok;
   assign ram_wr_addr   = {RW'(req_row), DW'(req_dimension)};
   assign ram_wr_data   = FEATURE_BITS'(req_feature);
   assign ram_rd_addr_a = {row_ff, t_ff};
   assign ram_rd_addr_b = {j_ff, t_ff};

   epd_ram #(
      .WIDTH (FEATURE_BITS),
      .DEPTH (2 ** AW)
   ) u_feature_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   // ---------------------------------------------------------------------
   // sequencer: walk columns j < i, features t < ndims, hand each sum over
   // ---------------------------------------------------------------------
   assign t_last    = ((DC_W'(t_ff) + DC_W'(1)) == ndims);
   assign pair_last = ((j_ff + RW'(1)) == row_ff);

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      j_in        = j_ff;
      t_in        = t_ff;
      issue       = 1'b0;
      sq_start    = 1'b0;
      tag_col_in  = tag_col_ff;
      tag_last_in = tag_last_ff;
      sum_in      = sq_v_ff ? (sum_ff + SUM_W'(sq_ff)) : sum_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && emit_ok) begin
               row_in   = RW'(req_row);
               j_in     = '0;
               t_in     = '0;
               sum_in   = '0;
               // zero features: every distance is zero, skip the reads
               state_in = (ndims == '0) ? ST_HAND : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            t_in  = t_ff + DW'(1);
            if (t_last) begin
               t_in     = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !df_v_ff && !sq_v_ff) begin
               state_in = ST_HAND;
            end
         end
         ST_HAND: begin
            if (!sq_stat.busy) begin
               sq_start    = 1'b1;
               tag_col_in  = j_ff;
               tag_last_in = pair_last;
               sum_in      = '0;
               if (pair_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  j_in     = j_ff + RW'(1);
                  state_in = (ndims == '0) ? ST_HAND : ST_ISSUE;
               end
            end
         end
         ST_FLUSH: begin
            // last root still in the unit
            if (!sq_stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // difference, square, accumulate
   // ---------------------------------------------------------------------
   assign rd_v_in = issue;
   assign df_v_in = rd_v_ff;
   assign sq_v_in = df_v_ff;
   assign diff_in = {ram_rd_data_a[FEATURE_BITS-1], ram_rd_data_a} -
                    {ram_rd_data_b[FEATURE_BITS-1], ram_rd_data_b};
   assign prod    = $signed(diff_ff) * $signed(diff_ff);
   assign sq_in   = SQ_W'(prod);

   // ---------------------------------------------------------------------
   // square root, shared by all columns of the row
   // ---------------------------------------------------------------------
   epd_sqrt #(
      .SUM_W (SUM_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .root     (sq_root),
      .stat     (sq_stat)
   );

   // result capture, one transfer per finished root
   assign rsp_valid_in = sq_stat.done;
   assign rsp_row_in   = sq_stat.done ? IDX_W'(row_ff) : rsp_row_ff;
   assign rsp_col_in   = sq_stat.done ? IDX_W'(tag_col_ff) : rsp_col_ff;
   assign rsp_dist_in  = sq_stat.done ? DIST_W'(sq_root) : rsp_dist_ff;
   assign rsp_last_in  = sq_stat.done ? tag_last_ff : rsp_last_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_count_ff    <= VECTOR_COUNT_RST;
         dimension_count_ff <= DIMENSION_COUNT_RST;
         state_ff           <= ST_IDLE;
         rd_v_ff            <= 1'b0;
         df_v_ff            <= 1'b0;
         sq_v_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         vector_count_ff    <= vector_count_in;
         dimension_count_ff <= dimension_count_in;
         state_ff           <= state_in;
         rd_v_ff            <= rd_v_in;
         df_v_ff            <= df_v_in;
         sq_v_ff            <= sq_v_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      j_ff        <= j_in;
      t_ff        <= t_in;
      diff_ff     <= diff_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      tag_col_ff  <= tag_col_in;
      tag_last_ff <= tag_last_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   // the last column of a row leaves only after the sequencer went idle
   a_last_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == ST_IDLE))
      else $error("last result while sequencer still running");

   // entries are strictly below the diagonal
   a_lower_triangle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_col_ff < rsp_row_ff))
      else $error("result column not below its row");

   // a new sum is never handed over a root in progress
   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_stat.busy)
      else $error("square root started while busy");

   // products only arrive while a column is being accumulated
   a_accum_phase: assert property (@(posedge clock) disable iff (reset)
      sq_v_ff |-> ((state_ff == ST_ISSUE) || (state_ff == ST_DRAIN)))
      else $error("product arrived outside accumulation");
`endif

endmodule

### rtl/epd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module epd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/epd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_sqrt
// iterative integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module epd_sqrt
   import epd_pkg::*;
#(
   parameter int SUM_W  = 39,
   localparam int RT_W  = (SUM_W + 1) / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  radicand,
   output logic [RT_W-1:0]   root,
   output epd_sqrt_stat_type stat
);

   localparam int RM_W  = RT_W + 3;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [2*RT_W-1:0] rad_ff,  rad_in;
   logic [RM_W-1:0]   rem_ff,  rem_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [RM_W-1:0]   rem_sh;
   logic [RM_W-1:0]   trial;
   logic              fits;

   // restoring digit step
   assign rem_sh = {rem_ff[RM_W-3:0], rad_ff[2*RT_W-1 -: 2]};
   assign trial  = RM_W'({root_ff, 2'b01});
   assign fits   = (rem_sh >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = (2*RT_W)'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*RT_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[RT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

### tb/epd_distance_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_distance_check_pkg
// expected-value tracking for the pairwise distance core: a private copy of
// the feature ram and the two count registers, and a queue of the distance
// entries that each accepted emit transfer must produce
// ----------------------------------------------------------------------------
package epd_distance_check_pkg;
   import epd_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  row_index;
      logic [IDX_W-1:0]  column_index;
      logic [DIST_W-1:0] distance;
      logic              last;
   } distance_entry_t;

   class distance_matrix_tracker;
      logic signed [FEAT_IN_W-1:0] features [DEF_MAX_VECTORS][DEF_MAX_DIMENSIONS];
      bit                          loaded   [DEF_MAX_VECTORS][DEF_MAX_DIMENSIONS];
      logic [CFG_W-1:0]            vector_count;
      logic [CFG_W-1:0]            dimension_count;
      distance_entry_t             pending_distances [$];
      int                          mismatch_count;

      function new();
         vector_count    = VECTOR_COUNT_RST;
         dimension_count = DIMENSION_COUNT_RST;
         mismatch_count  = 0;
      endfunction

      // counts above the ram size behave as the ram size
      function int rows_in_use();
         return (vector_count > DEF_MAX_VECTORS) ? DEF_MAX_VECTORS : int'(vector_count);
      endfunction

      function int dims_in_use();
         return (dimension_count > DEF_MAX_DIMENSIONS) ? DEF_MAX_DIMENSIONS
                                                       : int'(dimension_count);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_VECTOR_COUNT: begin
               vector_count = value;
            end
            CSR_DIMENSION_COUNT: begin
               dimension_count = value;
            end
            default: begin
            end
         endcase
      endfunction

      function longint unsigned floor_sqrt(longint unsigned value);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value) root = trial;
         end
         return root;
      endfunction

      function distance_entry_t predict_entry(int row, int col, int dims);
         distance_entry_t entry;
         longint unsigned sq_sum;
         longint          diff;
         sq_sum = 0;
         for (int d = 0; d < dims; d++) begin
            diff = longint'(features[row][d]) - longint'(features[col][d]);
            sq_sum += longint'(diff * diff);
         end
         entry.row_index    = row[IDX_W-1:0];
         entry.column_index = col[IDX_W-1:0];
         entry.distance     = floor_sqrt(sq_sum);
         entry.last         = (col + 1 == row);
         return entry;
      endfunction

      // highest row whose own and lower rows are fully loaded, -1 if none
      function int ready_top();
         int  top;
         bit  still;
         top   = -1;
         still = 1'b1;
         for (int r = 0; r < rows_in_use(); r++) begin
            for (int d = 0; d < dims_in_use(); d++) begin
               if (!loaded[r][d]) still = 1'b0;
            end
            if (still) top = r;
         end
         return top;
      endfunction

      // an emit that reads only loaded entries
      function bit row_readable(int row);
         return (row == 0) || (row >= rows_in_use()) || (row <= ready_top());
      endfunction

      function bit next_unloaded(output int row, output int dim);
         bit found;
         found = 1'b0;
         row   = 0;
         dim   = 0;
         for (int r = rows_in_use() - 1; r >= 0; r--) begin
            for (int d = dims_in_use() - 1; d >= 0; d--) begin
               if (!loaded[r][d]) begin
                  row   = r;
                  dim   = d;
                  found = 1'b1;
               end
            end
         end
         return found;
      endfunction

      function void take_command(logic [OP_W-1:0] op, int row, int dim,
                                 logic signed [FEAT_IN_W-1:0] feature);
         int nr;
         int nd;
         nr = rows_in_use();
         nd = dims_in_use();
         if (op == OP_LOAD) begin
            if (row < nr && dim < nd) begin
               features[row][dim] = feature;
               loaded[row][dim]   = 1'b1;
            end
         end else if (row != 0 && row < nr) begin
            for (int col = 0; col < row; col++)
               pending_distances.push_back(predict_entry(row, col, nd));
         end
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_distance(logic [IDX_W-1:0] row_index, logic [IDX_W-1:0] column_index,
                          logic [DIST_W-1:0] distance, logic last);
         distance_entry_t want;
         if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected result row %0d column %0d distance %0d",
                                      row_index, column_index, distance));
            return;
         end
         want = pending_distances.pop_front();
         if (row_index !== want.row_index)
            report_mismatch($sformatf("row_index %0d, expected %0d",
                                      row_index, want.row_index));
         if (column_index !== want.column_index)
            report_mismatch($sformatf("row %0d column_index %0d, expected %0d",
                                      want.row_index, column_index, want.column_index));
         if (distance !== want.distance)
            report_mismatch($sformatf("row %0d column %0d distance %0d, expected %0d",
                                      want.row_index, want.column_index, distance,
                                      want.distance));
         if (last !== want.last)
            report_mismatch($sformatf("row %0d column %0d last %0b, expected %0b",
                                      want.row_index, want.column_index, last, want.last));
      endtask
   endclass

endpackage

### tb/tb_euclidean_pairwise_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euclidean_pairwise_distance_core
// self-checking bench for the pairwise euclidean distance core
// ----------------------------------------------------------------------------
// Loads features and emits rows through the start/busy command port, and
// compares every strobed distance entry against a tracker that keeps its own
// feature ram and computes the exact floor square root. A directed part hits
// the largest distance, the tallest row, zero counts and counts above the ram
// size; random phases then fill rows with random features and emit rows that
// are fully loaded, mixed with out-of-range loads and empty emits. The sender
// works in bursts with random gaps; register writes happen only when idle.
// ----------------------------------------------------------------------------
module tb_euclidean_pairwise_distance_core;
   import epd_pkg::*;
   import epd_distance_check_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 12;
   // leaves a wide margin over the slowest run
   localparam int CYCLE_LIMIT     = 600000;
   // square root tail plus handoff after the last column of a row
   localparam int DRAIN_CYCLES    = 40;
   localparam int ITEMS_PER_PHASE = 24;
   localparam int RANDOM_PHASES   = 6;

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        start            = 1'b0;
   logic [OP_W-1:0]             req_operation    = OP_LOAD;
   logic [IDX_W-1:0]            req_row          = '0;
   logic [IDX_W-1:0]            req_dimension    = '0;
   logic signed [FEAT_IN_W-1:0] req_feature      = '0;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index        = CSR_VECTOR_COUNT;
   logic [CFG_W-1:0]            csr_write_data   = '0;

   logic                        busy;
   logic                        rsp_valid;
   logic [IDX_W-1:0]            rsp_row_index;
   logic [IDX_W-1:0]            rsp_column_index;
   logic [DIST_W-1:0]           rsp_distance;
   logic                        rsp_last;

   distance_matrix_tracker tracker;
   int cycle_count = 0;
   int burst_left  = 0;

   always #HALF_PERIOD clock = ~clock;

   euclidean_pairwise_distance_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_row          (req_row),
      .req_dimension    (req_dimension),
      .req_feature      (req_feature),
      .rsp_valid        (rsp_valid),
      .rsp_row_index    (rsp_row_index),
      .rsp_column_index (rsp_column_index),
      .rsp_distance     (rsp_distance),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // every strobed entry is taken at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         tracker.check_distance(rsp_row_index, rsp_column_index, rsp_distance, rsp_last);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // mostly random values, with the two extremes and zero kept frequent
   function automatic logic signed [FEAT_IN_W-1:0] random_feature();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // bursts of random length, random gaps between them, sometimes long runs
   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // one command transfer: start stays high until the core is not busy
   task automatic send_command(input logic [OP_W-1:0] op, input int row, input int dim,
                               input logic signed [FEAT_IN_W-1:0] feature);
      start         <= 1'b1;
      req_operation <= op;
      req_row       <= row[IDX_W-1:0];
      req_dimension <= dim[IDX_W-1:0];
      req_feature   <= feature;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      tracker.take_command(op, row, dim, feature);
      pace_sender();
   endtask

   // wait until every expected entry has come and the core has settled
   task automatic drain();
      start <= 1'b0;
      burst_left = 0;
      while (tracker.pending_distances.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // both count registers, back to back while the core is idle
   task automatic write_registers(input int vectors, input int dims);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_VECTOR_COUNT;
      csr_write_data   <= vectors[CFG_W-1:0];
      @(posedge clock);
      tracker.write_register(CSR_VECTOR_COUNT, vectors[CFG_W-1:0]);
      csr_index        <= CSR_DIMENSION_COUNT;
      csr_write_data   <= dims[CFG_W-1:0];
      @(posedge clock);
      tracker.write_register(CSR_DIMENSION_COUNT, dims[CFG_W-1:0]);
      csr_write_enable <= 1'b0;
   endtask

   // one random transfer; only loads that write and emits that stream count
   task automatic random_item(inout int counted);
      int nr;
      int nd;
      int top;
      int row;
      int dim;
      int pick;
      bit found;
      nr   = tracker.rows_in_use();
      nd   = tracker.dims_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         pick  = $urandom_range(0, 9);
         found = 1'b0;
         // fill the lowest unloaded entry so emits reach deeper rows
         if (pick < 6) found = tracker.next_unloaded(row, dim);
         if (!found && pick < 9) begin
            row   = $urandom_range(0, nr - 1);
            dim   = $urandom_range(0, nd - 1);
            found = 1'b1;
         end
         // noise, often outside the counts and so ignored
         if (!found) begin
            row = $urandom_range(0, 63);
            dim = $urandom_range(0, 63);
         end
         if (row < nr && dim < nd) counted++;
         send_command(OP_LOAD, row, dim, random_feature());
      end else begin
         top  = tracker.ready_top();
         pick = $urandom_range(0, 9);
         if (pick < 3 && top >= 1)
            row = top;
         else if (pick < 7 && top >= 1)
            row = $urandom_range(1, top);
         else
            row = $urandom_range(0, 63);
         // never touch features that were not loaded
         if (!tracker.row_readable(row)) row = 0;
         if (row != 0 && row < nr) counted++;
         send_command(OP_EMIT, row, $urandom_range(0, 63), random_feature());
      end
   endtask

   initial begin
      int counted;
      int vectors;
      int dims;
      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset counts: row zero streams nothing, then the largest distance
      send_command(OP_EMIT, 0, 0, 16'sh7fff);
      for (int d = 0; d < DEF_MAX_DIMENSIONS; d++) send_command(OP_LOAD, 0, d, 16'sh8000);
      for (int d = 0; d < DEF_MAX_DIMENSIONS; d++) send_command(OP_LOAD, 1, d, 16'sh7fff);
      send_command(OP_EMIT, 1, 63, 16'sh8000);
      drain();

      // one feature per vector, tallest row with 63 entries
      write_registers(DEF_MAX_VECTORS, 1);
      for (int r = 2; r < DEF_MAX_VECTORS; r++) send_command(OP_LOAD, r, 0, random_feature());
      send_command(OP_LOAD, 5, 1, random_feature());
      send_command(OP_EMIT, 63, 0, '0);
      send_command(OP_EMIT, 0, 0, '0);
      drain();

      // zero vectors: every load and emit is dropped
      write_registers(0, 5);
      send_command(OP_LOAD, 0, 0, 16'sh1234);
      send_command(OP_EMIT, 3, 0, '0);
      send_command(OP_EMIT, 0, 0, '0);
      drain();

      // zero dimensions with vectors over the ram size: all distances zero
      write_registers(100, 0);
      send_command(OP_LOAD, 2, 0, 16'sh7fff);
      send_command(OP_EMIT, 10, 0, '0);
      send_command(OP_EMIT, 63, 0, '0);
      drain();

      // both counts past the ram size behave as full size
      write_registers(127, 127);
      send_command(OP_LOAD, 1, 63, '0);
      send_command(OP_EMIT, 1, 0, '0);
      drain();

      // random phases, each with its own counts
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               vectors = 4;
               dims    = DEF_MAX_DIMENSIONS;
            end
            1: begin
               vectors = 1;
               dims    = 7;
            end
            2: begin
               vectors = DEF_MAX_VECTORS;
               dims    = 2;
            end
            3: begin
               // dimension counts just above the point where the square root stops being hidden
               vectors = $urandom_range(8, 16);
               dims    = $urandom_range(17, 20);
            end
            default: begin
               vectors = $urandom_range(2, 12);
               dims    = $urandom_range(1, 6);
            end
         endcase
         write_registers(vectors, dims);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) random_item(counted);
         drain();
      end

      if (tracker.mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
